>>> rtl/core/tlb_pkg.sv
// Shared types and constants of the two-layer blit pixel engine.
package tlb_pkg;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_BLIT_WIDTH   = 3'd0,
		REG_START_COL    = 3'd1,
		REG_HEIGHT_M1    = 3'd2,
		REG_START_ROW    = 3'd3,
		REG_MODE_BITS    = 3'd4,
		REG_DISPLAY_SEL  = 3'd5,
		REG_COLOR_WORD   = 3'd6,
		REG_FILL_PEN     = 3'd7
	} tlb_reg_t;

	localparam int unsigned REG_IDX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 16;
	localparam int unsigned PEN_BITS = 8;
	localparam int unsigned PAL_BITS = 4;
	localparam int unsigned VALUE_BITS = PEN_BITS + PAL_BITS;
	localparam int unsigned MODE_BITS_W = 10;

	// Mode bit positions
	localparam int unsigned MODE_FLIPX   = 0;
	localparam int unsigned MODE_FLIPY   = 1;
	localparam int unsigned MODE_IRQ     = 3;
	localparam int unsigned MODE_FILL    = 5;
	localparam int unsigned MODE_HIDDEN  = 6;
	localparam int unsigned MODE_LAYER   = 7;
	localparam int unsigned MODE_REPLACE = 9;

	localparam logic [PEN_BITS-1:0] PEN_CLEAR = 8'hff;

	// Non-coordinate configuration, used by the back end
	typedef struct packed {
		logic [MODE_BITS_W-1:0]   mode;
		logic [1:0]               disp;
		logic [CFG_DATA_BITS-1:0] color;
		logic [PEN_BITS-1:0]      fill;
	} tlb_mode_cfg_t;

	// Per-item classification from the front end
	typedef struct packed {
		logic empty;
		logic last;
	} tlb_flags_t;

endpackage

>>> rtl/core/tlb_ifs.sv
// Channel interfaces: source byte stream, pixel write stream, config writes.
interface tlb_in_if;
	logic                         valid;
	logic                         ready;
	logic [tlb_pkg::PEN_BITS-1:0] src_byte;

	modport source (output valid, output src_byte, input ready);
	modport sink (input valid, input src_byte, output ready);
endinterface

interface tlb_pix_if #(
	parameter int unsigned COORD_BITS = 9
);
	logic                           valid;
	logic                           ready;
	logic [COORD_BITS-1:0]          pix_row;
	logic [COORD_BITS-1:0]          pix_col;
	logic                           dest_layer;
	logic                           dest_buffer;
	logic [tlb_pkg::VALUE_BITS-1:0] pixel_value;
	logic                           write_enable;
	logic                           last_pixel;
	logic                           done_irq;

	modport source (
		output valid, output pix_row, output pix_col, output dest_layer,
		output dest_buffer, output pixel_value, output write_enable,
		output last_pixel, output done_irq, input ready
	);
	modport sink (
		input valid, input pix_row, input pix_col, input dest_layer,
		input dest_buffer, input pixel_value, input write_enable,
		input last_pixel, input done_irq, output ready
	);
endinterface

interface tlb_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tlb_pkg::REG_IDX_BITS-1:0]  reg_index;
	logic [tlb_pkg::CFG_DATA_BITS-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/core/tlb_regs.sv
// Configuration register file.
module tlb_regs #(
	parameter int unsigned COORD_BITS = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [tlb_pkg::REG_IDX_BITS-1:0]  wr_index,
	input  logic [tlb_pkg::CFG_DATA_BITS-1:0] wr_data,
	output logic [COORD_BITS-1:0]             blit_width,
	output logic [COORD_BITS-1:0]             start_col,
	output logic [COORD_BITS-1:0]             height_m1,
	output logic [COORD_BITS-1:0]             start_row,
	output tlb_pkg::tlb_mode_cfg_t            mode_cfg
);

	logic [COORD_BITS-1:0]  width_q, scol_q, hm1_q, srow_q;
	tlb_pkg::tlb_mode_cfg_t mcfg_q;
	tlb_pkg::tlb_reg_t      idx;

	assign idx = tlb_pkg::tlb_reg_t'(wr_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
			scol_q  <= '0;
			hm1_q   <= '0;
			srow_q  <= '0;
			mcfg_q  <= '0;
		end else if (wr_en) begin
			case (idx)
				tlb_pkg::REG_BLIT_WIDTH:  width_q <= wr_data[COORD_BITS-1:0];
				tlb_pkg::REG_START_COL:   scol_q <= wr_data[COORD_BITS-1:0];
				tlb_pkg::REG_HEIGHT_M1:   hm1_q <= wr_data[COORD_BITS-1:0];
				tlb_pkg::REG_START_ROW:   srow_q <= wr_data[COORD_BITS-1:0];
				tlb_pkg::REG_MODE_BITS:   mcfg_q.mode <= wr_data[tlb_pkg::MODE_BITS_W-1:0];
				tlb_pkg::REG_DISPLAY_SEL: mcfg_q.disp <= wr_data[1:0];
				tlb_pkg::REG_COLOR_WORD:  mcfg_q.color <= wr_data;
				tlb_pkg::REG_FILL_PEN:    mcfg_q.fill <= wr_data[tlb_pkg::PEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign blit_width = width_q;
	assign start_col  = scol_q;
	assign height_m1  = hm1_q;
	assign start_row  = srow_q;
	assign mode_cfg   = mcfg_q;

endmodule

>>> rtl/core/tlb_front.sv
// Front end: accepts source beats and walks the rectangle counters.
module tlb_front #(
	parameter int unsigned COORD_BITS = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [COORD_BITS-1:0] blit_width,
	input  logic [COORD_BITS-1:0] height_m1,
	output logic [COORD_BITS-1:0] col_step,
	output logic [COORD_BITS-1:0] row_step,
	output tlb_pkg::tlb_flags_t   flags
);

	logic [COORD_BITS-1:0] col_step_q, row_step_q, height;
	logic [COORD_BITS:0]   col_inc, row_inc;
	logic                  empty, row_end, blit_end;

	assign height   = height_m1 + COORD_BITS'(1);
	assign empty    = (blit_width == '0) || (height == '0);
	assign col_inc  = {1'b0, col_step_q} + (COORD_BITS+1)'(1);
	assign row_inc  = {1'b0, row_step_q} + (COORD_BITS+1)'(1);
	assign row_end  = col_inc >= {1'b0, blit_width};
	assign blit_end = row_end && (row_inc >= {1'b0, height});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_step_q <= '0;
			row_step_q <= '0;
		end else if (accept) begin
			if (empty || blit_end) begin
				col_step_q <= '0;
				row_step_q <= '0;
			end else if (row_end) begin
				col_step_q <= '0;
				row_step_q <= row_inc[COORD_BITS-1:0];
			end else begin
				col_step_q <= col_inc[COORD_BITS-1:0];
			end
		end
	end

	assign col_step    = col_step_q;
	assign row_step    = row_step_q;
	assign flags.empty = empty;
	assign flags.last  = empty || blit_end;

endmodule

>>> rtl/core/tlb_queue.sv
// Short FIFO between front and back ends.
module tlb_queue #(
	parameter int unsigned WIDTH = 28,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
		ptr_next = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
	endfunction

	assign not_full  = count_q != CNT_BITS'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

>>> rtl/core/tlb_back.sv
// Back end: forms the pixel write and holds it in the output register.
module tlb_back #(
	parameter int unsigned COORD_BITS = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic [tlb_pkg::PEN_BITS-1:0]  src_byte,
	input  logic [COORD_BITS-1:0]         col_step,
	input  logic [COORD_BITS-1:0]         row_step,
	input  tlb_pkg::tlb_flags_t           flags,
	input  logic [COORD_BITS-1:0]         start_col,
	input  logic [COORD_BITS-1:0]         start_row,
	input  tlb_pkg::tlb_mode_cfg_t        mode_cfg,
	tlb_pix_if.source                     pix
);

	logic                           valid_q;
	logic [COORD_BITS-1:0]          row_q, col_q, row_d, col_d;
	logic                           layer_q, buffer_q, we_q, last_q, irq_q;
	logic [tlb_pkg::VALUE_BITS-1:0] value_q, value_d;
	logic                           we_d, layer, buffer;
	logic [tlb_pkg::PEN_BITS-1:0]   pen;
	logic [tlb_pkg::PAL_BITS-1:0]   pal;

	assign q_pop = q_valid && (!valid_q || pix.ready);

	assign layer  = mode_cfg.mode[tlb_pkg::MODE_LAYER];
	assign buffer = mode_cfg.mode[tlb_pkg::MODE_HIDDEN] ^ mode_cfg.disp[layer];
	assign pal    = mode_cfg.color[tlb_pkg::PAL_BITS-1:0];

	always_comb begin
		pen = src_byte;
		if (mode_cfg.mode[tlb_pkg::MODE_REPLACE] &&
		    (src_byte == mode_cfg.color[tlb_pkg::PEN_BITS-1:0])) begin
			pen = mode_cfg.color[2*tlb_pkg::PEN_BITS-1:tlb_pkg::PEN_BITS];
		end
		col_d = mode_cfg.mode[tlb_pkg::MODE_FLIPX] ? start_col - col_step
		                                           : start_col + col_step;
		row_d = mode_cfg.mode[tlb_pkg::MODE_FLIPY] ? start_row - row_step
		                                           : start_row + row_step;
		if (flags.empty) begin
			row_d   = '0;
			col_d   = '0;
			value_d = '0;
			we_d    = 1'b0;
		end else if (mode_cfg.mode[tlb_pkg::MODE_FILL]) begin
			// all-ones fill pen drops the palette
			value_d = (mode_cfg.fill == tlb_pkg::PEN_CLEAR) ? {{tlb_pkg::PAL_BITS{1'b0}},
			          tlb_pkg::PEN_CLEAR} : {pal, mode_cfg.fill};
			we_d    = 1'b1;
		end else begin
			value_d = {pal, pen};
			we_d    = pen != tlb_pkg::PEN_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pix.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			row_q    <= row_d;
			col_q    <= col_d;
			layer_q  <= layer;
			buffer_q <= buffer;
			value_q  <= value_d;
			we_q     <= we_d;
			last_q   <= flags.last;
			irq_q    <= flags.last && mode_cfg.mode[tlb_pkg::MODE_IRQ];
		end
	end

	assign pix.valid        = valid_q;
	assign pix.pix_row      = row_q;
	assign pix.pix_col      = col_q;
	assign pix.dest_layer   = layer_q;
	assign pix.dest_buffer  = buffer_q;
	assign pix.pixel_value  = value_q;
	assign pix.write_enable = we_q;
	assign pix.last_pixel   = last_q;
	assign pix.done_irq     = irq_q;

endmodule

>>> rtl/core/two_layer_blit_pixel_engine.sv
// Top level of the two-layer rectangle blit pixel engine.
//
// Channels:
//   cfg - register writes (reg_index, wdata); always ready. Write only while
//         the engine is idle: no beat in flight and the result stream drained.
//   src - one source pen byte per beat (any value in fill mode; it still
//         paces the walk, one beat per pixel).
//   pix - one pixel write per source beat: row, column, layer, buffer,
//         12-bit value, write enable, last flag and done interrupt.
// Throughput: one beat per cycle sustained while pix is ready. An accepted
// beat goes through the queue entry, then the output register, to pix;
// the front counters are read combinationally at accept, with no register.
// The rectangle is walked row by row; the front end advances the column and
// row offsets on each accepted beat and tags the final pixel. An empty
// rectangle (width zero or height wrapping to zero) answers every beat with
// one non-writing last result.
// Stall: when pix is held off, the output register keeps its beat and the
// two-entry queue absorbs two more; src.ready falls once the queue is full.
// Reset (arst_n low): registers, counters and queue clear; pix.valid drops.
module two_layer_blit_pixel_engine #(
	parameter int unsigned COORD_BITS = 9
) (
	input  logic      clk,
	input  logic      arst_n,
	tlb_cfg_if.sink   cfg,
	tlb_in_if.sink    src,
	tlb_pix_if.source pix
);

	// queue entry: source byte, column and row offsets, flags
	localparam int unsigned Q_WIDTH = tlb_pkg::PEN_BITS + 2*COORD_BITS + 2;
	localparam int unsigned Q_DEPTH = 2;

	logic [COORD_BITS-1:0]  blit_width, start_col, height_m1, start_row;
	tlb_pkg::tlb_mode_cfg_t mode_cfg;

	logic [COORD_BITS-1:0]        f_col, f_row, b_col, b_row;
	tlb_pkg::tlb_flags_t          f_flags, b_flags;
	logic [tlb_pkg::PEN_BITS-1:0] b_byte;
	logic [Q_WIDTH-1:0]           q_in, q_out;
	logic                         q_not_full, q_not_empty, q_pop, src_accept;

	// config port never stalls
	assign cfg.ready = 1'b1;

	tlb_regs #(.COORD_BITS(COORD_BITS)) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg.valid),
		.wr_index   (cfg.reg_index),
		.wr_data    (cfg.wdata),
		.blit_width (blit_width),
		.start_col  (start_col),
		.height_m1  (height_m1),
		.start_row  (start_row),
		.mode_cfg   (mode_cfg)
	);

	// ready follows queue space only, so a stalled output does not block
	// intake until the queue is actually full
	assign src.ready  = q_not_full;
	assign src_accept = src.valid && q_not_full;

	tlb_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (src_accept),
		.blit_width (blit_width),
		.height_m1  (height_m1),
		.col_step   (f_col),
		.row_step   (f_row),
		.flags      (f_flags)
	);

	assign q_in = {src.src_byte, f_col, f_row, f_flags};

	tlb_queue #(.WIDTH(Q_WIDTH), .DEPTH(Q_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (src_accept),
		.push_data (q_in),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_out)
	);

	assign {b_byte, b_col, b_row, b_flags} = q_out;

	tlb_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_pop     (q_pop),
		.src_byte  (b_byte),
		.col_step  (b_col),
		.row_step  (b_row),
		.flags     (b_flags),
		.start_col (start_col),
		.start_row (start_row),
		.mode_cfg  (mode_cfg),
		.pix       (pix)
	);

endmodule

>>> rtl/core/tlb_checker.sv
// Port-level checker for the blit pixel engine, bound to the top level.
module tlb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_valid,
	input logic        pix_ready,
	input logic [11:0] pixel_value,
	input logic        write_enable,
	input logic        last_pixel,
	input logic        done_irq
);

	// interrupt only on the final pixel
	a_irq_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && done_irq |-> last_pixel)
		else $error("done_irq without last_pixel");

	// an all-ones low byte is written only without palette (fill escape)
	a_clear_pen: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && write_enable && (pixel_value[7:0] == 8'hff)
		|-> (pixel_value[11:8] == 4'h0))
		else $error("transparent pen written with palette");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid)
		else $error("pixel beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> $stable(pixel_value) && $stable(write_enable)
			&& $stable(last_pixel))
		else $error("pixel beat changed while stalled");

endmodule

bind two_layer_blit_pixel_engine tlb_checker u_tlb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pix_valid    (pix.valid),
	.pix_ready    (pix.ready),
	.pixel_value  (pix.pixel_value),
	.write_enable (pix.write_enable),
	.last_pixel   (pix.last_pixel),
	.done_irq     (pix.done_irq)
);
